// ===== rtl/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// Shadow memory access checker package
// Shared widths, command and fault codes, shadow marks and the fault
// classification function.
// ----------------------------------------------------------------------------
package smac_pkg;

   localparam int ADDR_BITS        = 32;
   localparam int SCALE_SHIFT      = 3;
   localparam int SIZE_W           = 16;
   localparam int LEN_W            = SIZE_W + 1;
   localparam int OFF_W            = ADDR_BITS + 2;
   localparam int GRAN_W           = OFF_W - SCALE_SHIFT;
   localparam int SHADOW_DEPTH_DEF = 4096;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_END  = 2'd1;

   localparam logic [ADDR_BITS-1:0] REGION_END_RST = ADDR_BITS'(32767);

   localparam logic [2:0] GRANULE_MASK = 3'd7;

   localparam logic [7:0] MARK_GLOBAL   = 8'hFA;
   localparam logic [7:0] MARK_STACK_LO = 8'hF1;
   localparam logic [7:0] MARK_STACK_HI = 8'hF4;
   localparam logic [7:0] MARK_SCOPE    = 8'hF8;

   typedef enum logic [2:0] {
      CMD_CHECK    = 3'd0,
      CMD_POISON   = 3'd1,
      CMD_UNPOISON = 3'd2,
      CMD_SCOPE    = 3'd3,
      CMD_GLOBAL   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_OOB     = 3'd1,
      KIND_GLOBAL  = 3'd2,
      KIND_STACK   = 3'd3,
      KIND_SCOPE   = 3'd4,
      KIND_UNKNOWN = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LO,
      S_HI,
      S_FILL,
      S_TAIL,
      S_SCAN,
      S_CLASS
   } state_type;

   function automatic kind_type classify(input logic [7:0] v);
      kind_type k;
      if (v <= 8'(GRANULE_MASK)) begin
         k = KIND_OOB;
      end else if (v == MARK_GLOBAL) begin
         k = KIND_GLOBAL;
      end else if (v inside {[MARK_STACK_LO:MARK_STACK_HI]}) begin
         k = KIND_STACK;
      end else if (v == MARK_SCOPE) begin
         k = KIND_SCOPE;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

endpackage

// ===== rtl/smac_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/shadow_memory_access_checker.sv =====
// ----------------------------------------------------------------------------
// Shadow memory access checker
// Keeps one shadow byte per 8-byte granule of a guarded region, checks
// accesses against it and rewrites ranges of it on command.
//
//   channel   ports                       handshake
//   request   start, busy, req_*          taken when start && !busy
//   response  rsp_valid, rsp_*            one-cycle strobe, always taken
//   config    csr_valid, csr_ready, csr_* written when valid && ready
//
// Steps: a check inside the region runs S_LO, S_HI, then S_SCAN, which reads
// the shadow bytes one per cycle through the RAM read port, plus S_CLASS when
// a partial granule sends classification to the next byte; a check outside
// the region or of size zero ends in S_LO, an unused command in S_IDLE. A
// range command runs S_LO, S_HI and S_FILL; unpoison and register global add
// a tail write for a partial granule, register global a redzone pass when it
// fits. Reset starts a sweep that zeroes SHADOW_DEPTH entries with busy high,
// one per cycle. Responses cannot stall; config writes are taken every cycle.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker
   import smac_pkg::*;
#(
   parameter int SHADOW_DEPTH = SHADOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_cmd,
   input  logic [ADDR_BITS-1:0] req_addr,
   input  logic [SIZE_W-1:0]    req_size,
   input  logic [SIZE_W-1:0]    req_redzone_size,
   input  logic [7:0]           req_poison_value,
   input  logic                 req_is_write,
   input  logic [31:0]          req_access_ip,
   output logic                 rsp_valid,
   output logic                 rsp_violation,
   output logic [2:0]           rsp_bug_kind,
   output logic [ADDR_BITS-1:0] rsp_fault_addr,
   output logic [SIZE_W-1:0]    rsp_fault_size,
   output logic                 rsp_fault_is_write,
   output logic [31:0]          rsp_fault_ip,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int IW = $clog2(SHADOW_DEPTH);
   localparam logic signed [GRAN_W-1:0] DEPTH_G = GRAN_W'(SHADOW_DEPTH);
   localparam logic signed [GRAN_W-1:0] LAST_G  = GRAN_W'(SHADOW_DEPTH - 1);

   state_type state_ff, state_in;

   logic [ADDR_BITS-1:0] base_ff, end_ff;

   cmd_type              cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [SIZE_W-1:0]    size_ff, rz_ff;
   logic [7:0]           pv_ff;
   logic                 wr_ff;
   logic [31:0]          ip_ff;

   logic                     rz_phase_ff, rz_phase_in;
   logic signed [GRAN_W-1:0] g_ff, g_in;
   logic signed [GRAN_W-1:0] ge_ff, ge_in;
   logic                     pend_ff, pend_in;
   logic                     plast_ff, plast_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_viol_ff, rsp_viol_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic                 rsp_wr_ff, rsp_wr_in;
   logic [31:0]          rsp_ip_ff, rsp_ip_in;

   logic                    ram_we;
   logic [IW-1:0]           ram_waddr, ram_raddr;
   logic [7:0]              ram_wdata, ram_rdata;

   logic [LEN_W-1:0]        aligned;
   logic [LEN_W-1:0]        alu_k;
   logic signed [OFF_W-1:0] alu_sum;
   logic signed [GRAN_W-1:0] alu_gran;
   logic [7:0]              fill_val;
   logic [2:0]              last_off;
   logic                    flagged;
   logic [7:0]              class_val;
   logic                    fin_zero, fin_fault;
   kind_type                fin_kind;
   logic                    rz_fits;

   smac_ram #(
      .WIDTH(8),
      .DEPTH(SHADOW_DEPTH)
   ) u_shadow (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Config registers: always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         end_ff  <= REGION_END_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_REGION_BASE) begin
            base_ff <= csr_wdata;
         end else if (csr_index == CSR_REGION_END) begin
            end_ff <= csr_wdata;
         end
      end
   end

   // Shared offset unit: addr + k - base, then granule index.
   assign aligned  = (LEN_W'(size_ff) + LEN_W'(GRANULE_MASK)) & ~LEN_W'(GRANULE_MASK);
   assign rz_fits  = LEN_W'(rz_ff) >= aligned;
   assign alu_sum  = OFF_W'(addr_ff) + OFF_W'(alu_k) - OFF_W'(base_ff);
   assign alu_gran = GRAN_W'(alu_sum >>> SCALE_SHIFT);
   assign last_off = addr_ff[2:0] + size_ff[2:0] - 3'd1;

   always_comb begin
      if (state_ff == S_LO) begin
         alu_k = rz_phase_ff ? aligned : '0;
      end else if (cmd_ff == CMD_CHECK) begin
         alu_k = LEN_W'(size_ff - SIZE_W'(1));
      end else if (rz_phase_ff) begin
         alu_k = LEN_W'(rz_ff);
      end else if (cmd_ff == CMD_SCOPE) begin
         alu_k = aligned;
      end else begin
         alu_k = LEN_W'(size_ff);
      end
   end

   always_comb begin
      if (rz_phase_ff) begin
         fill_val = MARK_GLOBAL;
      end else begin
         case (cmd_ff)
            CMD_POISON: fill_val = pv_ff;
            CMD_SCOPE:  fill_val = MARK_SCOPE;
            default:    fill_val = 8'd0;
         endcase
      end
   end

   assign flagged   = !plast_ff ||
                      ($signed({6'd0, last_off}) >= $signed({ram_rdata[7], ram_rdata}));
   assign class_val = (g_ff >= DEPTH_G) ? 8'd0 : ram_rdata;
   assign ram_raddr = (g_ff >= 0 && g_ff < DEPTH_G) ? g_ff[IW-1:0] : '0;

   always_comb begin
      state_in    = state_ff;
      rz_phase_in = rz_phase_ff;
      g_in        = g_ff;
      ge_in       = ge_ff;
      pend_in     = 1'b0;
      plast_in    = plast_ff;
      ram_we      = 1'b0;
      ram_waddr   = g_ff[IW-1:0];
      ram_wdata   = fill_val;
      fin_zero    = 1'b0;
      fin_fault   = 1'b0;
      fin_kind    = KIND_NONE;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = 8'd0;
            g_in      = g_ff + GRAN_W'(1);
            if (g_ff == LAST_G) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rz_phase_in = 1'b0;
            if (start) begin
               if (req_cmd inside {CMD_CHECK, CMD_POISON, CMD_UNPOISON, CMD_SCOPE,
                                   CMD_GLOBAL}) begin
                  state_in = S_LO;
               end else begin
                  fin_zero = 1'b1;
               end
            end
         end
         S_LO: begin
            if (cmd_ff == CMD_CHECK) begin
               if (alu_sum < 0 || addr_ff > end_ff || size_ff == '0) begin
                  fin_zero = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  g_in     = alu_gran;
                  state_in = S_HI;
               end
            end else begin
               // clamp below the region to the first granule
               g_in     = (alu_sum < 0) ? '0 : alu_gran;
               state_in = S_HI;
            end
         end
         S_HI: begin
            ge_in    = alu_gran;
            state_in = (cmd_ff == CMD_CHECK) ? S_SCAN : S_FILL;
         end
         S_FILL: begin
            if (g_ff < ge_ff && g_ff < DEPTH_G) begin
               ram_we = 1'b1;
               g_in   = g_ff + GRAN_W'(1);
            end else if (!rz_phase_ff &&
                         (cmd_ff == CMD_UNPOISON || cmd_ff == CMD_GLOBAL)) begin
               if (size_ff[2:0] != 3'd0) begin
                  state_in = S_TAIL;
               end else if (cmd_ff == CMD_GLOBAL && rz_fits) begin
                  rz_phase_in = 1'b1;
                  state_in    = S_LO;
               end else begin
                  fin_zero = 1'b1;
               end
            end else begin
               fin_zero = 1'b1;
            end
         end
         S_TAIL: begin
            // partial granule keeps its valid byte count
            ram_waddr = ge_ff[IW-1:0];
            ram_wdata = {5'd0, size_ff[2:0]};
            ram_we    = (ge_ff >= 0 && ge_ff < DEPTH_G);
            if (cmd_ff == CMD_GLOBAL && rz_fits) begin
               rz_phase_in = 1'b1;
               state_in    = S_LO;
            end else begin
               fin_zero = 1'b1;
            end
         end
         S_SCAN: begin
            if (pend_ff && ram_rdata != 8'd0) begin
               if (!flagged) begin
                  fin_zero = 1'b1;
               end else if (ram_rdata <= 8'(GRANULE_MASK)) begin
                  // partial granule: classify by the next byte, already being read
                  state_in = S_CLASS;
               end else begin
                  fin_fault = 1'b1;
                  fin_kind  = classify(ram_rdata);
               end
            end else if (pend_ff && plast_ff) begin
               fin_zero = 1'b1;
            end else if (g_ff >= DEPTH_G) begin
               fin_zero = 1'b1;
            end else begin
               pend_in  = 1'b1;
               plast_in = (g_ff == ge_ff);
               g_in     = g_ff + GRAN_W'(1);
            end
         end
         S_CLASS: begin
            fin_fault = 1'b1;
            fin_kind  = classify(class_val);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_zero || fin_fault) begin
         state_in = S_IDLE;
      end

      rsp_valid_in = fin_zero || fin_fault;
      rsp_viol_in  = fin_fault;
      rsp_kind_in  = fin_kind;
      rsp_addr_in  = fin_fault ? addr_ff : '0;
      rsp_size_in  = fin_fault ? size_ff : '0;
      rsp_wr_in    = fin_fault ? wr_ff : 1'b0;
      rsp_ip_in    = fin_fault ? ip_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         g_ff         <= '0;
         rz_phase_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         g_ff         <= g_in;
         rz_phase_ff  <= rz_phase_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ge_ff       <= ge_in;
      plast_ff    <= plast_in;
      rsp_viol_ff <= rsp_viol_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_size_ff <= rsp_size_in;
      rsp_wr_ff   <= rsp_wr_in;
      rsp_ip_ff   <= rsp_ip_in;
      if (state_ff == S_IDLE && start) begin
         cmd_ff  <= cmd_type'(req_cmd);
         addr_ff <= req_addr;
         size_ff <= req_size;
         rz_ff   <= req_redzone_size;
         pv_ff   <= req_poison_value;
         wr_ff   <= req_is_write;
         ip_ff   <= req_access_ip;
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_violation      = rsp_viol_ff;
   assign rsp_bug_kind       = rsp_kind_ff;
   assign rsp_fault_addr     = rsp_addr_ff;
   assign rsp_fault_size     = rsp_size_ff;
   assign rsp_fault_is_write = rsp_wr_ff;
   assign rsp_fault_ip       = rsp_ip_ff;

endmodule
